[design/fsr_pkg.sv]
// Package for the flow slot registry: sizes, command and status codes,
// register indexes and the slot store types. No dependencies.
package fsr_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOW_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIRECTION = 2'd1;

    localparam logic [1:0] CMD_BEGIN    = 2'd0;
    localparam logic [1:0] CMD_COMPLETE = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  dir;
        logic [31:0] source;
        logic [31:0] dest;
        logic [63:0] bytes;
        logic [63:0] start_ms;
        logic [63:0] end_ms;
    } meta_t;

    typedef struct packed {
        logic        id_we;
        logic        meta_we;
        slot_idx_t   addr;
        logic [63:0] id;
        meta_t       meta;
    } store_wr_t;

endpackage

[design/fsr_cmd_if.sv]
// Command channel of the flow slot registry: valid/ready plus the command
// payload. No dependencies.
interface fsr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  flow_type;
    logic [2:0]  direction;
    logic [31:0] source_id;
    logic [31:0] dest_id;
    logic [63:0] byte_count;
    logic [63:0] target_id;
    logic [63:0] now_ms;

    modport source (
        output valid, cmd, flow_type, direction, source_id, dest_id,
               byte_count, target_id, now_ms,
        input  ready
    );
    modport sink (
        input  valid, cmd, flow_type, direction, source_id, dest_id,
               byte_count, target_id, now_ms,
        output ready
    );
endinterface

[design/fsr_rsp_if.sv]
// Response channel of the flow slot registry: valid/ready plus status and id.
// No dependencies.
interface fsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] new_id;

    modport source (
        output valid, status, new_id,
        input  ready
    );
    modport sink (
        input  valid, status, new_id,
        output ready
    );
endinterface

[design/fsr_slot_store.sv]
// Slot store: flow id memory and flow record memory, one write port and
// one registered read port each. Depends on fsr_pkg.
module fsr_slot_store (
    input  logic              clk,
    input  fsr_pkg::store_wr_t wr,
    input  fsr_pkg::slot_idx_t rd_addr,
    output logic [63:0]       id_rdata,
    output fsr_pkg::meta_t    meta_rdata
);
    import fsr_pkg::*;

    logic [63:0] id_mem [SLOTS];
    meta_t       meta_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.id_we)
        begin
            id_mem[wr.addr] <= wr.id;
        end
        if (wr.meta_we)
        begin
            meta_mem[wr.addr] <= wr.meta;
        end
        id_rdata   <= id_mem[rd_addr];
        meta_rdata <= meta_mem[rd_addr];
    end

endmodule

[design/flow_slot_registry.sv]
// Flow slot registry top level: command decode, slot flags, id scan and
// response register. Depends on fsr_pkg, fsr_cmd_if, fsr_rsp_if, fsr_slot_store.
//
// One command is handled at a time. Begin, and any rejected or unused command,
// passes from the command transfer through the result registers to the output
// registers: the free slot is picked from the active/completed flags in the
// transfer cycle. Complete and cancel walk the flow id memory one slot per cycle
// through its single read port, and answer at a match or after the last slot.
// The next command is taken once the response has moved to the output
// register, even while that response still waits for the consumer.
module flow_slot_registry (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fsr_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [fsr_pkg::CFG_DATA_W-1:0] cfg_data,
    fsr_cmd_if.sink                       cmd_ch,
    fsr_rsp_if.source                     rsp_ch
);
    import fsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0]       max_type_reg, max_type_next;
    logic [2:0]       max_dir_reg, max_dir_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [63:0]      next_id_reg, next_id_next;
    slot_idx_t        scan_reg, scan_next;
    logic             complete_reg, complete_next;
    logic [63:0]      target_reg, target_next;
    logic [63:0]      now_reg, now_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [63:0]      res_id_reg, res_id_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [1:0]       rsp_status_reg, rsp_status_next;
    logic [63:0]      rsp_id_reg, rsp_id_next;

    store_wr_t   wr;
    slot_idx_t   rd_addr;
    logic [63:0] id_rdata;
    meta_t       meta_rdata;

    logic      accept;
    logic      begin_bad;
    logic      free_hit;
    slot_idx_t free_slot;
    logic      scan_hit;
    logic      scan_last;

    fsr_slot_store u_store (
        .clk        (clk),
        .wr         (wr),
        .rd_addr    (rd_addr),
        .id_rdata   (id_rdata),
        .meta_rdata (meta_rdata)
    );

    assign cmd_ch.ready  = (state_reg == S_IDLE);
    assign accept        = cmd_ch.valid && cmd_ch.ready;
    assign rsp_ch.valid  = rsp_valid_reg;
    assign rsp_ch.status = rsp_status_reg;
    assign rsp_ch.new_id = rsp_id_reg;

    assign begin_bad = (cmd_ch.flow_type > max_type_reg) ||
                       (cmd_ch.direction > max_dir_reg) ||
                       (cmd_ch.byte_count == 64'd0);

    assign scan_hit  = active_reg[scan_reg] && (id_rdata == target_reg);
    assign scan_last = (scan_reg == SLOT_W'(SLOTS - 1));

    // lowest slot that is neither active nor completed
    always_comb
    begin
        free_hit  = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i] && !done_reg[i])
            begin
                free_hit  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    // read one slot ahead of the compare
    always_comb
    begin
        if (state_reg == S_SCAN && !scan_last)
        begin
            rd_addr = scan_reg + SLOT_W'(1);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        max_type_next   = max_type_reg;
        max_dir_next    = max_dir_reg;
        active_next     = active_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        scan_next       = scan_reg;
        complete_next   = complete_reg;
        target_next     = target_reg;
        now_next        = now_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ch.ready;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        wr              = '0;

        if (cfg_we)
        begin
            case (cfg_idx)
                REG_MAX_FLOW_TYPE: max_type_next = cfg_data[3:0];
                REG_MAX_DIRECTION: max_dir_next  = cfg_data[2:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_id_next = 64'd0;
                    state_next  = S_RESP;
                    case (cmd_ch.cmd)
                        CMD_BEGIN:
                        begin
                            if (begin_bad)
                            begin
                                res_status_next = ST_INVALID;
                            end
                            else if (count_reg >= CNT_W'(SLOTS) || !free_hit)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr.id_we          = 1'b1;
                                wr.meta_we        = 1'b1;
                                wr.addr           = free_slot;
                                wr.id             = next_id_reg;
                                wr.meta.kind      = cmd_ch.flow_type;
                                wr.meta.dir       = cmd_ch.direction;
                                wr.meta.source    = cmd_ch.source_id;
                                wr.meta.dest      = cmd_ch.dest_id;
                                wr.meta.bytes     = cmd_ch.byte_count;
                                wr.meta.start_ms  = cmd_ch.now_ms;
                                wr.meta.end_ms    = 64'd0;
                                active_next[free_slot] = 1'b1;
                                count_next        = count_reg + CNT_W'(1);
                                next_id_next      = next_id_reg + 64'd1;
                                res_status_next   = ST_OK;
                                res_id_next       = next_id_reg;
                            end
                        end
                        CMD_COMPLETE, CMD_CANCEL:
                        begin
                            scan_next     = '0;
                            complete_next = (cmd_ch.cmd == CMD_COMPLETE);
                            target_next   = cmd_ch.target_id;
                            now_next      = cmd_ch.now_ms;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    active_next[scan_reg] = 1'b0;
                    if (complete_reg)
                    begin
                        done_next[scan_reg] = 1'b1;
                        wr.meta_we          = 1'b1;
                        wr.addr             = scan_reg;
                        wr.meta             = meta_rdata;
                        wr.meta.end_ms      = now_reg;
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ch.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_id_next     = res_id_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_type_reg   <= 4'd15;
            max_dir_reg    <= 3'd7;
            active_reg     <= '0;
            done_reg       <= '0;
            count_reg      <= '0;
            next_id_reg    <= 64'd1;
            scan_reg       <= '0;
            complete_reg   <= 1'b0;
            target_reg     <= '0;
            now_reg        <= '0;
            res_status_reg <= ST_OK;
            res_id_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_id_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            max_type_reg   <= max_type_next;
            max_dir_reg    <= max_dir_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            scan_reg       <= scan_next;
            complete_reg   <= complete_next;
            target_reg     <= target_next;
            now_reg        <= now_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_id_reg     <= rsp_id_next;
        end
    end

endmodule

[design/fsr_checker.sv]
// Port-level checks for the flow slot registry and the bind that attaches
// them. Depends on fsr_pkg and flow_slot_registry.
module fsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [63:0] rsp_new_id
);
    import fsr_pkg::*;

    // response held until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_new_id))
        else $error("stalled response changed");

    // only a successful begin carries an id
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_new_id == 64'd0)
        else $error("id on a failed command");

    // one command in flight
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in flight");

endmodule

bind flow_slot_registry fsr_checker u_fsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .rsp_valid  (rsp_ch.valid),
    .rsp_ready  (rsp_ch.ready),
    .rsp_status (rsp_ch.status),
    .rsp_new_id (rsp_ch.new_id)
);

[bench/tb.sv]
// Self-checking bench for flow_slot_registry: drives begin/complete/cancel commands,
// predicts each response from a slot-table model and checks status and new_id.
// Depends on fsr_pkg, fsr_cmd_if, fsr_rsp_if and the flow_slot_registry RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE = SLOTS + 4;
    localparam int PHASE_ITEMS = 215;
    localparam int STALL_LIMIT = 2000;
    localparam int HELD_BUDGET = 10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  flow_type;
        logic [2:0]  direction;
        logic [31:0] source_id;
        logic [31:0] dest_id;
        logic [63:0] byte_count;
        logic [63:0] target_id;
        logic [63:0] now_ms;
    } flow_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] new_id;
    } flow_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    fsr_cmd_if cmd_ch();
    fsr_rsp_if rsp_ch();

    flow_slot_registry u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd_ch   (cmd_ch),
        .rsp_ch   (rsp_ch)
    );

    always #2 clk = ~clk;

    // slot table model
    logic [3:0]  lim_type = 4'hF;
    logic [2:0]  lim_dir = 3'h7;
    logic        slot_live [SLOTS];
    logic        slot_held [SLOTS];
    logic [63:0] slot_id [SLOTS];
    int          live_count = 0;
    logic [63:0] issue_id = 64'd1;

    flow_cmd_t cmd_backlog [$];
    flow_rsp_t rsp_due [$];
    flow_cmd_t cur_cmd;
    bit steady = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;
    int stall_cycles = 0;
    int mismatches = 0;

    function automatic flow_rsp_t registry_apply(input flow_cmd_t c);
        flow_rsp_t r;
        int hit;
        r.status = ST_INVALID;
        r.new_id = '0;
        hit = -1;
        case (c.cmd)
            CMD_BEGIN:
            begin
                if (c.flow_type > lim_type || c.direction > lim_dir || c.byte_count == 0)
                    r.status = ST_INVALID;
                else if (live_count >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (!slot_live[s] && !slot_held[s] && hit < 0)
                            hit = s;
                    if (hit < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_id[hit] = issue_id;
                        issue_id = issue_id + 64'd1;
                        slot_live[hit] = 1'b1;
                        live_count++;
                        r.new_id = slot_id[hit];
                        r.status = ST_OK;
                    end
                end
            end
            CMD_COMPLETE, CMD_CANCEL:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_live[s] && slot_id[s] == c.target_id && hit < 0)
                        hit = s;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    slot_live[hit] = 1'b0;
                    slot_held[hit] = (c.cmd == CMD_COMPLETE);
                    if (live_count > 0)
                        live_count--;
                    r.status = ST_OK;
                end
            end
            default:
                r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic int held_count();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
            if (slot_held[s])
                n++;
        return n;
    endfunction

    function automatic bit pick_live(output logic [63:0] id);
        int n;
        int k;
        n = 0;
        id = '0;
        for (int s = 0; s < SLOTS; s++)
            if (slot_live[s])
                n++;
        if (n == 0)
            return 1'b0;
        k = $urandom_range(0, n - 1);
        for (int s = 0; s < SLOTS; s++)
            if (slot_live[s])
            begin
                if (k == 0)
                    id = slot_id[s];
                k--;
            end
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand_u64();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return 64'($urandom_range(0, 3));
            2: return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic flow_cmd_t mk(input logic [1:0] cmd, input logic [3:0] ft,
                                     input logic [2:0] dir, input logic [31:0] src,
                                     input logic [31:0] dst, input logic [63:0] bytes,
                                     input logic [63:0] tgt, input logic [63:0] now);
        flow_cmd_t c;
        c.cmd = cmd;
        c.flow_type = ft;
        c.direction = dir;
        c.source_id = src;
        c.dest_id = dst;
        c.byte_count = bytes;
        c.target_id = tgt;
        c.now_ms = now;
        return c;
    endfunction

    function automatic flow_cmd_t random_item();
        flow_cmd_t c;
        int r;
        logic [63:0] id;
        c = mk(CMD_BEGIN, 4'($urandom), 3'($urandom), $urandom, $urandom,
               rand_u64(), rand_u64(), rand_u64());
        r = $urandom_range(0, 99);
        if (r < 38)
        begin
            c.flow_type = 4'($urandom_range(0, lim_type));
            c.direction = 3'($urandom_range(0, lim_dir));
            if (c.byte_count == 0)
                c.byte_count = 64'd1;
        end
        else if (r < 76)
        begin
            // completes are rationed: held slots never come back
            if (r >= 74 && held_count() < HELD_BUDGET)
                c.cmd = CMD_COMPLETE;
            else
                c.cmd = CMD_CANCEL;
            if (pick_live(id))
                c.target_id = id;
        end
        else if (r < 84)
        begin
            if ($urandom_range(0, 2) == 0)
                c.byte_count = '0;
        end
        else if (r < 93)
        begin
            if ($urandom_range(0, 1))
            begin
                c.cmd = CMD_CANCEL;
                c.target_id = issue_id - 64'($urandom_range(0, 3));
            end
            else
                c.cmd = $urandom_range(0, 1) ? CMD_COMPLETE : CMD_CANCEL;
        end
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    task automatic push_item(input flow_cmd_t c);
        while (cmd_backlog.size() >= 2)
            @(negedge clk);
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || rsp_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_idx)
                REG_MAX_FLOW_TYPE: lim_type <= cfg_data[3:0];
                REG_MAX_DIRECTION: lim_dir <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // command driver
    always @(posedge clk)
    begin
        flow_rsp_t predicted;
        bit taken;
        if (rst_n)
        begin
            taken = cmd_ch.valid && cmd_ch.ready;
            if (taken)
            begin
                predicted = registry_apply(cur_cmd);
                rsp_due.push_back(predicted);
            end
            if (!cmd_ch.valid || taken)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 && !steady && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(0, 17);
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    cmd_ch.cmd <= cur_cmd.cmd;
                    cmd_ch.flow_type <= cur_cmd.flow_type;
                    cmd_ch.direction <= cur_cmd.direction;
                    cmd_ch.source_id <= cur_cmd.source_id;
                    cmd_ch.dest_id <= cur_cmd.dest_id;
                    cmd_ch.byte_count <= cur_cmd.byte_count;
                    cmd_ch.target_id <= cur_cmd.target_id;
                    cmd_ch.now_ms <= cur_cmd.now_ms;
                    cmd_ch.valid <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        flow_rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("unexpected response: status %0d new_id %h",
                           rsp_ch.status, rsp_ch.new_id);
                    mismatches++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.new_id !== want.new_id)
                    begin
                        $error("new_id: expected %h, got %h", want.new_id, rsp_ch.new_id);
                        mismatches++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 11) == 0)
            begin
                sink_gap = $urandom_range(0, 17);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [3:0] ft_sel [6];
        logic [3:0] dir_sel [6];
        logic [63:0] id;
        flow_cmd_t c;

        for (int s = 0; s < SLOTS; s++)
        begin
            slot_live[s] = 1'b0;
            slot_held[s] = 1'b0;
            slot_id[s] = '0;
        end
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_BEGIN;
        cmd_ch.flow_type = '0;
        cmd_ch.direction = '0;
        cmd_ch.source_id = '0;
        cmd_ch.dest_id = '0;
        cmd_ch.byte_count = '0;
        cmd_ch.target_id = '0;
        cmd_ch.now_ms = '0;
        rsp_ch.ready = 1'b0;
        ft_sel = '{4'hF, 4'h0, 4'h9, 4'hF, 4'h0, 4'h0};
        dir_sel = '{4'h7, 4'h8, 4'hF, 4'h0, 4'h3, 4'h0};
        ft_sel[5] = 4'($urandom);
        dir_sel[5] = 4'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits, field extremes, odd codes, then fill the table to capacity
        push_item(mk(CMD_BEGIN, 4'hF, 3'h7, '1, '1, '1, '0, '1));
        push_item(mk(CMD_BEGIN, 4'h0, 3'h0, '0, '0, 64'd1, '1, '0));
        push_item(mk(CMD_BEGIN, 4'h3, 3'h2, $urandom, $urandom, '0, '0, rand_u64()));
        push_item(mk(CMD_UNUSED, 4'h1, 3'h1, $urandom, $urandom, 64'd5, 64'd1, '0));
        push_item(mk(CMD_COMPLETE, 4'h0, 3'h0, '0, '0, '0, '0, '1));
        push_item(mk(CMD_CANCEL, 4'h0, 3'h0, '0, '0, '0, '1, '0));
        for (int k = 0; k < SLOTS - 2; k++)
            push_item(mk(CMD_BEGIN, 4'($urandom), 3'($urandom), $urandom, $urandom,
                         64'(k + 1), rand_u64(), rand_u64()));
        push_item(mk(CMD_BEGIN, 4'h2, 3'h4, $urandom, $urandom, 64'd9, '0, rand_u64()));
        push_item(mk(CMD_BEGIN, 4'h5, 3'h5, $urandom, $urandom, '0, '0, rand_u64()));
        push_item(mk(CMD_CANCEL, 4'h0, 3'h0, '0, '0, '0, 64'd2, rand_u64()));
        push_item(mk(CMD_COMPLETE, 4'h0, 3'h0, '0, '0, '0, 64'd1, rand_u64()));
        push_item(mk(CMD_COMPLETE, 4'h0, 3'h0, '0, '0, '0, 64'd1, rand_u64()));

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            repeat (SETTLE) @(posedge clk);
            set_reg(REG_MAX_FLOW_TYPE, ft_sel[ph]);
            set_reg(REG_MAX_DIRECTION, dir_sel[ph]);
            set_reg(ph[0] ? REG_SPARE_3 : REG_SPARE_2, 4'($urandom));
            if (ph == 5)
                steady = 1'b1;
            repeat (PHASE_ITEMS) push_item(random_item());
        end

        // retire every slot so begin runs out with no flow active
        wait_drained();
        while (held_count() < SLOTS)
        begin
            if (pick_live(id))
                c = mk(CMD_COMPLETE, '0, '0, $urandom, $urandom, rand_u64(), id, rand_u64());
            else
                c = mk(CMD_BEGIN, '0, '0, $urandom, $urandom, 64'd7, rand_u64(), rand_u64());
            push_item(c);
            wait_drained();
        end
        repeat (4)
            push_item(mk(CMD_BEGIN, '0, '0, $urandom, $urandom, '1, rand_u64(), rand_u64()));
        repeat (12) push_item(random_item());

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/fsr_pkg.sv
design/fsr_cmd_if.sv
design/fsr_rsp_if.sv
design/fsr_slot_store.sv
design/flow_slot_registry.sv
design/fsr_checker.sv
bench/tb.sv
